@@ design/mpd_pkg.sv @@
// Package for the motion pickup detector: widths, reset values, register
// indexes, word and command/status structs, and small helper functions.
// Depends on nothing; every other design file imports it.
package mpd_pkg;

  // Field and register widths.
  localparam int AXIS_WIDTH    = 16;
  localparam int EMA_FRAC_BITS = 16;
  localparam int TIME_W        = 32;
  localparam int THR_W         = 17;
  localparam int IVL_W         = 16;
  localparam int COOL_W        = 16;
  localparam int GAIN_W        = 16;
  localparam int MAG_W         = 16;
  localparam int BL_W          = 17;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  // Derived datapath widths.
  localparam int ROOT_W   = AXIS_WIDTH;
  localparam int SUM_W    = 2 * AXIS_WIDTH;
  localparam int REM_W    = ROOT_W + 2;
  localparam int BASE_W   = ROOT_W + EMA_FRAC_BITS;
  localparam int THR_FX_W = THR_W + EMA_FRAC_BITS;
  localparam int CMP_W    = (BASE_W > THR_FX_W) ? BASE_W : THR_FX_W;
  localparam int MUL_A_W  = (AXIS_WIDTH > GAIN_W) ? AXIS_WIDTH : GAIN_W;
  localparam int MUL_B_W  = BASE_W;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int CNT_W    = $clog2(ROOT_W + 1);
  localparam int SQ_LAST  = 3;

  // Register reset values.
  localparam logic [THR_W-1:0]  THR_RST  = THR_W'(2458);
  localparam logic [IVL_W-1:0]  IVL_RST  = IVL_W'(20);
  localparam logic [COOL_W-1:0] COOL_RST = COOL_W'(1500);
  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(1966);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE    = CFG_IDX_W'(0),
    CFG_THRESHOLD = CFG_IDX_W'(1),
    CFG_INTERVAL  = CFG_IDX_W'(2),
    CFG_COOLDOWN  = CFG_IDX_W'(3),
    CFG_EMA_GAIN  = CFG_IDX_W'(4)
  } cfg_idx_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_sel_t;

  typedef struct packed {
    logic [TIME_W-1:0]            time_ms;
    logic                         sample_ok;
    logic signed [AXIS_WIDTH-1:0] accel_x;
    logic signed [AXIS_WIDTH-1:0] accel_y;
    logic signed [AXIS_WIDTH-1:0] accel_z;
  } mpd_in_t;

  typedef struct packed {
    logic             sample_taken;
    logic [MAG_W-1:0] magnitude;
    logic             pickup_fired;
    logic [BL_W-1:0]  baseline;
  } mpd_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      cap;
    logic      check;
    logic      sq_mul;
    logic      sq_acc;
    axis_sel_t axis_sel;
    logic      root_step;
    logic      dev;
    logic      fire;
    logic      upd;
    logic      out_load;
  } mpd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;
    logic ok;
    logic seeded;
    logic out_free;
  } mpd_sts_t;

  function automatic logic [AXIS_WIDTH-1:0] axis_abs(input logic [AXIS_WIDTH-1:0] v);
    return v[AXIS_WIDTH-1] ? (~v + AXIS_WIDTH'(1)) : v;
  endfunction

  function automatic logic [MAG_W-1:0] sat_mag(input logic [ROOT_W-1:0] r);
    logic [ROOT_W+MAG_W-1:0] wide;
    wide = (ROOT_W + MAG_W)'(r);
    if (wide > (ROOT_W + MAG_W)'({MAG_W{1'b1}})) return {MAG_W{1'b1}};
    return MAG_W'(wide);
  endfunction

  function automatic logic [BL_W-1:0] sat_bl(input logic [ROOT_W-1:0] r);
    logic [ROOT_W+BL_W-1:0] wide;
    wide = (ROOT_W + BL_W)'(r);
    if (wide > (ROOT_W + BL_W)'({BL_W{1'b1}})) return {BL_W{1'b1}};
    return BL_W'(wide);
  endfunction

endpackage

@@ design/motion_pickup_detector_unit.sv @@
// Top level of the motion pickup detector: joins the controller and the
// datapath and holds the port-level assertions. Depends on mpd_pkg,
// mpd_ctrl and mpd_dp.
//
//   Channel   Direction  Handshake            Word
//   in_       input      in_valid / in_stall  mpd_in_t  (time, ok flag, axes)
//   out_      output     out_valid/out_stall  mpd_out_t (taken, magnitude, pickup, baseline)
//   cfg_      input      cfg_valid/cfg_ready  register index and write data
//
// An ignored word (disabled, early, or not sample_ok) goes from the check to its result;
// a seeding sample is squared, square-rooted bit-serially and seeds the baseline, a later
// one is also checked for pickup and updates the baseline; the controller then idles.
// Reset (rst_n low, synchronous) restores the register defaults and clears the
// schedule, cooldown and baseline. A stalled result holds the output register;
// the next word is taken meanwhile and waits at the end of its work for it.
module motion_pickup_detector_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mpd_pkg::mpd_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mpd_pkg::mpd_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mpd_pkg::*;

  mpd_cmd_t cmd;
  mpd_sts_t sts;

  // Configuration writes are always taken; the user must issue them only while idle, the block does not enforce it.
  assign cfg_ready = 1'b1;

  mpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mpd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // A word is worked on alone: the cycle after acceptance the input stalls.
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // A pickup can only fire on a processed sample.
  a_pick_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.pickup_fired || out_data.sample_taken))
    else $error("pickup flagged on an ignored word");

  // Ignored words report a zero magnitude.
  a_mag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.sample_taken |-> out_data.magnitude == '0)
    else $error("nonzero magnitude on an ignored word");

endmodule

@@ design/mpd_ctrl.sv @@
// Controller of the motion pickup detector: a one-hot state machine that
// sequences squaring, square root and baseline update. Depends on mpd_pkg.
module mpd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mpd_pkg::mpd_sts_t sts,
  output mpd_pkg::mpd_cmd_t cmd
);
  import mpd_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_SQ    = 8'b0000_0100,
    S_ROOT  = 8'b0000_1000,
    S_DEV   = 8'b0001_0000,
    S_FIRE  = 8'b0010_0000,
    S_UPD   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.axis_sel = AXIS_X;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        cnt_nxt   = '0;
        if (sts.skip || !sts.ok) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        // The product of one axis is added in the cycle after it is formed.
        cmd.sq_mul = (cnt_r != CNT_W'(SQ_LAST));
        cmd.sq_acc = (cnt_r != '0);
        if (cmd.sq_mul) begin
          cmd.axis_sel = axis_sel_t'(cnt_r[1:0]);
        end
        if (cnt_r == CNT_W'(SQ_LAST)) begin
          cnt_nxt   = '0;
          state_nxt = S_ROOT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          state_nxt = S_DEV;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_DEV: begin
        cmd.dev   = 1'b1;
        state_nxt = sts.seeded ? S_FIRE : S_DONE;
      end
      S_FIRE: begin
        cmd.fire  = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ design/mpd_dp.sv @@
// Datapath of the motion pickup detector: configuration registers, detector
// state, shared multiplier, bit-serial square root and output register.
// Depends on mpd_pkg; driven by mpd_ctrl through command and status structs.
module mpd_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  mpd_pkg::mpd_in_t               in_data,
  input  logic                           out_stall,
  output logic                           out_valid,
  output mpd_pkg::mpd_out_t              out_data,
  input  mpd_pkg::mpd_cmd_t              cmd,
  output mpd_pkg::mpd_sts_t              sts
);
  import mpd_pkg::*;

  // Configuration.
  logic              en_r;
  logic [THR_W-1:0]  thr_r;
  logic [IVL_W-1:0]  ivl_r;
  logic [COOL_W-1:0] cool_r;
  logic [GAIN_W-1:0] gain_r;

  // Detector state.
  logic [TIME_W-1:0] next_time_r;
  logic [TIME_W-1:0] cool_end_r;
  logic              seeded_r;
  logic [BASE_W-1:0] ema_r;

  // Per-word working registers.
  mpd_in_t            in_r;
  logic [SUM_W-1:0]   rad_r;
  logic [REM_W-1:0]   rem_r;
  logic [ROOT_W-1:0]  root_r;
  logic [BASE_W-1:0]  dev_r;
  logic               up_r;
  logic [MUL_P_W-1:0] prod_r;
  logic               taken_r;
  logic               picked_r;

  logic               out_valid_r;
  mpd_out_t           out_word_r;

  logic [AXIS_WIDTH-1:0]     axis_mag;
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic [REM_W-1:0]          rem_sh;
  logic [REM_W-1:0]          trial;
  logic [BASE_W-1:0]         mfx;
  logic [GAIN_W+BASE_W-1:0]  rnd;
  logic [BASE_W-1:0]         step;
  logic                      fire;

  assign sts.skip     = !en_r || (in_r.time_ms < next_time_r);
  assign sts.ok       = in_r.sample_ok;
  assign sts.seeded   = seeded_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  always_comb begin
    case (cmd.axis_sel)
      AXIS_X:  axis_mag = axis_abs(in_r.accel_x);
      AXIS_Y:  axis_mag = axis_abs(in_r.accel_y);
      AXIS_Z:  axis_mag = axis_abs(in_r.accel_z);
      default: axis_mag = '0;
    endcase
  end

  // One multiplier serves the squares and the gain product.
  assign mul_a = cmd.fire ? MUL_A_W'(gain_r) : MUL_A_W'(axis_mag);
  assign mul_b = cmd.fire ? dev_r : MUL_B_W'(axis_mag);

  // Restoring square root, one result bit per step.
  assign rem_sh = {rem_r[ROOT_W-1:0], rad_r[SUM_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  assign mfx  = {root_r, {EMA_FRAC_BITS{1'b0}}};
  assign fire = (in_r.time_ms >= cool_end_r) &&
                (CMP_W'(dev_r) >= CMP_W'({thr_r, {EMA_FRAC_BITS{1'b0}}}));

  // Gain product rounded half up, then scaled down by the Q0.16 gain.
  assign rnd  = prod_r[GAIN_W+BASE_W-1:0] + ((GAIN_W + BASE_W)'(1) << (GAIN_W - 1));
  assign step = rnd[GAIN_W +: BASE_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b0;
      thr_r       <= THR_RST;
      ivl_r       <= IVL_RST;
      cool_r      <= COOL_RST;
      gain_r      <= GAIN_RST;
      next_time_r <= '0;
      cool_end_r  <= '0;
      seeded_r    <= 1'b0;
      ema_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ENABLE:    en_r   <= cfg_data[0];
          CFG_THRESHOLD: thr_r  <= cfg_data[THR_W-1:0];
          CFG_INTERVAL:  ivl_r  <= cfg_data[IVL_W-1:0];
          CFG_COOLDOWN:  cool_r <= cfg_data[COOL_W-1:0];
          CFG_EMA_GAIN:  gain_r <= cfg_data[GAIN_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.check && !sts.skip) begin
        next_time_r <= in_r.time_ms + TIME_W'(ivl_r);
      end
      if (cmd.dev && !seeded_r) begin
        ema_r    <= mfx;
        seeded_r <= 1'b1;
      end
      if (cmd.fire && fire) begin
        cool_end_r <= in_r.time_ms + TIME_W'(cool_r);
      end
      if (cmd.upd) begin
        ema_r <= up_r ? (ema_r + step) : (ema_r - step);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      in_r <= in_data;
    end
    if (cmd.check) begin
      rad_r    <= '0;
      rem_r    <= '0;
      root_r   <= '0;
      taken_r  <= !sts.skip && in_r.sample_ok;
      picked_r <= 1'b0;
    end
    if (cmd.sq_mul || cmd.fire) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.sq_acc) begin
      rad_r <= rad_r + prod_r[SUM_W-1:0];
    end
    if (cmd.root_step) begin
      rad_r <= rad_r << 2;
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.dev) begin
      up_r  <= (mfx >= ema_r);
      dev_r <= (mfx >= ema_r) ? (mfx - ema_r) : (ema_r - mfx);
    end
    if (cmd.fire) begin
      picked_r <= fire;
    end
    if (cmd.out_load) begin
      out_word_r.sample_taken <= taken_r;
      out_word_r.magnitude    <= taken_r ? sat_mag(root_r) : '0;
      out_word_r.pickup_fired <= taken_r && picked_r;
      out_word_r.baseline     <= sat_bl(ema_r[BASE_W-1:EMA_FRAC_BITS]);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule
